// ----- hw/rtl/cps_pkg.sv -----
`timescale 1ns / 1ps
package cps_pkg;
  // Region codes of a result.
  typedef enum logic [1:0] {
    REGION_A     = 2'd0,
    REGION_B     = 2'd1,
    REGION_INNER = 2'd2,
    REGION_ZERO  = 2'd3
  } region_e;
  // Quotient bits of the interior ratio.
  localparam int unsigned RatioBits = 32;
  // Quotient bits resolved in each divider stage.
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages = RatioBits / BitsPerStage;
endpackage

// ----- hw/rtl/closest_point_on_segment_unit.sv -----
`timescale 1ns / 1ps
// Closest point on a 2D segment, fixed point.
// Pipeline from the accepting edge of start to the edge that takes the
// result: five front stages, 16 divider stages and two offset stages.
// Throughput: one request per cycle; the divider is cut into 16 stages of two
// quotient bits each, and the products into two stages of partial products.
// Reset clears only the valid bits of the pipeline; busy is always low.
module closest_point_on_segment_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] closest_x_o,
  output logic signed [COORD_WIDTH-1:0] closest_y_o,
  output logic [1:0]                    region_o
);
  // FRAC_BITS only names the binary point; the geometry does not depend on it.
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;          // difference width
  localparam int unsigned MW = CW;              // magnitude width of a difference
  localparam int unsigned PW = 2 * MW + 2;      // product sums
  localparam int unsigned RB = cps_pkg::RatioBits;
  localparam int unsigned BS = cps_pkg::BitsPerStage;
  localparam int unsigned NS = cps_pkg::DivStages;
  localparam int unsigned HW = (MW + 1) / 2;    // half width for split products

  assign busy = 1'b0;

  // Stage 1: differences.
  logic v1_q;
  logic signed [DW-1:0] ux_q, uy_q, wx_q, wy_q;
  logic signed [CW-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    ax1_q <= a_x_i[CW-1:0]; ay1_q <= a_y_i[CW-1:0];
    bx1_q <= b_x_i[CW-1:0]; by1_q <= b_y_i[CW-1:0];
    ux_q <= DW'(signed'(b_x_i[CW-1:0])) - DW'(signed'(a_x_i[CW-1:0]));
    uy_q <= DW'(signed'(b_y_i[CW-1:0])) - DW'(signed'(a_y_i[CW-1:0]));
    wx_q <= DW'(signed'(point_x_i[CW-1:0])) - DW'(signed'(a_x_i[CW-1:0]));
    wy_q <= DW'(signed'(point_y_i[CW-1:0])) - DW'(signed'(a_y_i[CW-1:0]));
  end

  // Magnitudes and signs of the differences (magnitude fits in CW bits plus one).
  logic [DW-1:0] mux, muy, mwx, mwy;
  assign mux = ux_q[DW-1] ? DW'(-ux_q) : DW'(ux_q);
  assign muy = uy_q[DW-1] ? DW'(-uy_q) : DW'(uy_q);
  assign mwx = wx_q[DW-1] ? DW'(-wx_q) : DW'(wx_q);
  assign mwy = wy_q[DW-1] ? DW'(-wy_q) : DW'(wy_q);

  // Stage 2: magnitude registers.
  logic v2_q;
  logic [DW-1:0] mux2_q, muy2_q, mwx2_q, mwy2_q;
  logic sx2_q, sy2_q, nux2_q, nuy2_q;
  logic signed [CW-1:0] ax2_q, ay2_q, bx2_q, by2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    mux2_q <= mux; muy2_q <= muy; mwx2_q <= mwx; mwy2_q <= mwy;
    sx2_q <= wx_q[DW-1] ^ ux_q[DW-1];
    sy2_q <= wy_q[DW-1] ^ uy_q[DW-1];
    nux2_q <= ux_q[DW-1]; nuy2_q <= uy_q[DW-1];
    ax2_q <= ax1_q; ay2_q <= ay1_q; bx2_q <= bx1_q; by2_q <= by1_q;
  end

  // Stage 3: partial products, each operand split in halves.
  localparam int unsigned QW = DW - HW;
  typedef logic [2*QW-1:0] pp_t;
  function automatic pp_t pmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    pmul = pp_t'(a) * pp_t'(b);
  endfunction
  logic v3_q;
  pp_t pxx_q [4], pyy_q [4], lxx_q [4], lyy_q [4];
  logic sx3_q, sy3_q, nux3_q, nuy3_q;
  logic [DW-1:0] mux3_q, muy3_q;
  logic signed [CW-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    pxx_q[0] <= pmul(QW'(mwx2_q[HW-1:0]), QW'(mux2_q[HW-1:0]));
    pxx_q[1] <= pmul(QW'(mwx2_q[HW-1:0]), QW'(mux2_q[DW-1:HW]));
    pxx_q[2] <= pmul(QW'(mwx2_q[DW-1:HW]), QW'(mux2_q[HW-1:0]));
    pxx_q[3] <= pmul(QW'(mwx2_q[DW-1:HW]), QW'(mux2_q[DW-1:HW]));
    pyy_q[0] <= pmul(QW'(mwy2_q[HW-1:0]), QW'(muy2_q[HW-1:0]));
    pyy_q[1] <= pmul(QW'(mwy2_q[HW-1:0]), QW'(muy2_q[DW-1:HW]));
    pyy_q[2] <= pmul(QW'(mwy2_q[DW-1:HW]), QW'(muy2_q[HW-1:0]));
    pyy_q[3] <= pmul(QW'(mwy2_q[DW-1:HW]), QW'(muy2_q[DW-1:HW]));
    lxx_q[0] <= pmul(QW'(mux2_q[HW-1:0]), QW'(mux2_q[HW-1:0]));
    lxx_q[1] <= pmul(QW'(mux2_q[HW-1:0]), QW'(mux2_q[DW-1:HW]));
    lxx_q[2] <= pmul(QW'(mux2_q[DW-1:HW]), QW'(mux2_q[HW-1:0]));
    lxx_q[3] <= pmul(QW'(mux2_q[DW-1:HW]), QW'(mux2_q[DW-1:HW]));
    lyy_q[0] <= pmul(QW'(muy2_q[HW-1:0]), QW'(muy2_q[HW-1:0]));
    lyy_q[1] <= pmul(QW'(muy2_q[HW-1:0]), QW'(muy2_q[DW-1:HW]));
    lyy_q[2] <= pmul(QW'(muy2_q[DW-1:HW]), QW'(muy2_q[HW-1:0]));
    lyy_q[3] <= pmul(QW'(muy2_q[DW-1:HW]), QW'(muy2_q[DW-1:HW]));
    sx3_q <= sx2_q; sy3_q <= sy2_q; nux3_q <= nux2_q; nuy3_q <= nuy2_q;
    mux3_q <= mux2_q; muy3_q <= muy2_q;
    ax3_q <= ax2_q; ay3_q <= ay2_q; bx3_q <= bx2_q; by3_q <= by2_q;
  end

  // Stage 4: combine partial products into full products.
  localparam int unsigned FW = 2 * DW;
  typedef logic [FW-1:0] full_t;
  function automatic full_t comb(input pp_t p0, input pp_t p1, input pp_t p2, input pp_t p3);
    comb = full_t'(p0) + (full_t'(p1) << HW) + (full_t'(p2) << HW) + (full_t'(p3) << (2 * HW));
  endfunction
  logic v4_q;
  full_t fx_q, fy_q, flx_q, fly_q;
  logic sx4_q, sy4_q, nux4_q, nuy4_q;
  logic [DW-1:0] mux4_q, muy4_q;
  logic signed [CW-1:0] ax4_q, ay4_q, bx4_q, by4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    fx_q <= comb(pxx_q[0], pxx_q[1], pxx_q[2], pxx_q[3]);
    fy_q <= comb(pyy_q[0], pyy_q[1], pyy_q[2], pyy_q[3]);
    flx_q <= comb(lxx_q[0], lxx_q[1], lxx_q[2], lxx_q[3]);
    fly_q <= comb(lyy_q[0], lyy_q[1], lyy_q[2], lyy_q[3]);
    sx4_q <= sx3_q; sy4_q <= sy3_q; nux4_q <= nux3_q; nuy4_q <= nuy3_q;
    mux4_q <= mux3_q; muy4_q <= muy3_q;
    ax4_q <= ax3_q; ay4_q <= ay3_q; bx4_q <= bx3_q; by4_q <= by3_q;
  end

  // Stage 5: projection and squared length, then classification.
  localparam int unsigned SW = FW + 2;
  logic signed [SW-1:0] proj_d;
  logic [SW-1:0] len_d;
  assign proj_d = (sx4_q ? -signed'(SW'(fx_q)) : signed'(SW'(fx_q)))
                + (sy4_q ? -signed'(SW'(fy_q)) : signed'(SW'(fy_q)));
  assign len_d = SW'(flx_q) + SW'(fly_q);

  logic v5_q;
  logic [SW-1:0] rem5_q, len5_q;
  logic [1:0] reg5_q;
  logic nux5_q, nuy5_q;
  logic [DW-1:0] mux5_q, muy5_q;
  logic signed [CW-1:0] ax5_q, ay5_q, bx5_q, by5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (len_d == '0) reg5_q <= cps_pkg::REGION_ZERO;
    else if (proj_d <= 0) reg5_q <= cps_pkg::REGION_A;
    else if (SW'(proj_d) >= len_d) reg5_q <= cps_pkg::REGION_B;
    else reg5_q <= cps_pkg::REGION_INNER;
    rem5_q <= SW'(proj_d); len5_q <= len_d;
    nux5_q <= nux4_q; nuy5_q <= nuy4_q; mux5_q <= mux4_q; muy5_q <= muy4_q;
    ax5_q <= ax4_q; ay5_q <= ay4_q; bx5_q <= bx4_q; by5_q <= by4_q;
  end

  // Divider pipeline: restoring division, two quotient bits per stage.
  // For the interior case the remainder stays below len, so SW+1 bits suffice.
  typedef struct packed {
    logic                 v;
    logic [SW:0]          rem;
    logic [SW-1:0]        len;
    logic [RB-1:0]        t;
    logic [1:0]           rgn;
    logic                 nux, nuy;
    logic [DW-1:0]        mux, muy;
    logic signed [CW-1:0] ax, ay, bx, by;
  } div_t;
  div_t div_in;
  div_t ds_q [NS];
  always_comb begin
    div_in.v = v5_q; div_in.rem = (SW+1)'(rem5_q); div_in.len = len5_q;
    div_in.t = '0; div_in.rgn = reg5_q;
    div_in.nux = nux5_q; div_in.nuy = nuy5_q;
    div_in.mux = mux5_q; div_in.muy = muy5_q;
    div_in.ax = ax5_q; div_in.ay = ay5_q; div_in.bx = bx5_q; div_in.by = by5_q;
  end
  for (genvar s = 0; s < NS; s++) begin : g_div
    div_t cur, nx;
    if (s == 0) begin : g_first
      assign cur = div_in;
    end else begin : g_next
      assign cur = ds_q[s-1];
    end
    always_comb begin
      logic [SW:0] r;
      nx = cur;
      r = cur.rem;
      for (int b = 0; b < BS; b++) begin
        r = {r[SW-1:0], 1'b0};
        nx.t = {nx.t[RB-2:0], 1'b0};
        if (r >= (SW+1)'(cur.len)) begin
          r = r - (SW+1)'(cur.len);
          nx.t[0] = 1'b1;
        end
      end
      nx.rem = r;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ds_q[s].v <= 1'b0;
      else ds_q[s] <= nx;
    end
  end

  // Offset stage 1: |U| * t, split over the halves of t.
  localparam int unsigned TH = RB / 2;
  localparam int unsigned OW = DW + RB;
  div_t de;
  assign de = ds_q[NS-1];
  logic v6_q;
  logic [DW+TH-1:0] oxl_q, oxh_q, oyl_q, oyh_q;
  logic [1:0] rgn6_q;
  logic nux6_q, nuy6_q;
  logic signed [CW-1:0] ax6_q, ay6_q, bx6_q, by6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= de.v;
  end
  always_ff @(posedge clk_i) begin
    oxl_q <= (DW+TH)'(de.mux) * (DW+TH)'(de.t[TH-1:0]);
    oxh_q <= (DW+TH)'(de.mux) * (DW+TH)'(de.t[RB-1:TH]);
    oyl_q <= (DW+TH)'(de.muy) * (DW+TH)'(de.t[TH-1:0]);
    oyh_q <= (DW+TH)'(de.muy) * (DW+TH)'(de.t[RB-1:TH]);
    rgn6_q <= de.rgn; nux6_q <= de.nux; nuy6_q <= de.nuy;
    ax6_q <= de.ax; ay6_q <= de.ay; bx6_q <= de.bx; by6_q <= de.by;
  end

  // Offset stage 2: sum, round half up, apply sign.
  logic [OW-1:0] sx_w, sy_w;
  assign sx_w = OW'(oxl_q) + (OW'(oxh_q) << TH) + (OW'(1) << (RB - 1));
  assign sy_w = OW'(oyl_q) + (OW'(oyh_q) << TH) + (OW'(1) << (RB - 1));
  logic [CW-1:0] offx, offy;
  assign offx = nux6_q ? CW'(-sx_w[OW-1:RB]) : CW'(sx_w[OW-1:RB]);
  assign offy = nuy6_q ? CW'(-sy_w[OW-1:RB]) : CW'(sy_w[OW-1:RB]);

  logic v7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    case (rgn6_q)
      cps_pkg::REGION_B: begin
        closest_x_o <= bx6_q; closest_y_o <= by6_q;
      end
      cps_pkg::REGION_INNER: begin
        closest_x_o <= ax6_q + signed'(offx); closest_y_o <= ay6_q + signed'(offy);
      end
      default: begin
        closest_x_o <= ax6_q; closest_y_o <= ay6_q;
      end
    endcase
    region_o <= rgn6_q;
  end
  assign done_o = v7_q;

  // Checks on the valid chain and on the zero-length region.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> ##(NS + 2) done_o) else $error("result strobe missing");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && len5_q == '0) |-> reg5_q == cps_pkg::REGION_ZERO)
    else $error("zero length not flagged");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> v1_q) else $error("request lost");
endmodule

// ----- test/closest_point_on_segment_unit_tb.sv -----
`timescale 1ns / 1ps
module closest_point_on_segment_unit_tb;

  localparam int          NumRandom   = 1300;
  localparam int          DrainCycles = 40;
  localparam int          CycleLimit  = 600000;
  localparam logic [31:0] CoordMax    = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin    = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] px, py, ax, ay, bx, by;
  } query_t;

  typedef struct packed {
    logic signed [31:0] cx, cy;
    cps_pkg::region_e   region;
  } nearest_t;

  typedef struct packed {
    query_t   q;
    bit       typed;
    nearest_t want;
  } vector_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               done_o;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, a_x_i = '0, a_y_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0;
  logic signed [31:0] closest_x_o, closest_y_o;
  logic [1:0]         region_o;

  nearest_t pending_points[$];
  vector_t  typed_rows[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       requests = 0;
  int       region_hits[4] = '{0, 0, 0, 0};

  closest_point_on_segment_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_x_i, .point_y_i, .a_x_i, .a_y_i, .b_x_i, .b_y_i,
    .done_o, .closest_x_o, .closest_y_o, .region_o
  );

  always #10 clk_i = ~clk_i;

  // Exact projection in wide signed arithmetic, then a truncated 32-bit ratio.
  function automatic nearest_t nearest_point(input query_t q);
    logic signed [127:0] ux, uy, wx, wy, proj, span, ratio, mag, ofs;
    nearest_t r;
    ux = 128'(q.bx) - 128'(q.ax);
    uy = 128'(q.by) - 128'(q.ay);
    wx = 128'(q.px) - 128'(q.ax);
    wy = 128'(q.py) - 128'(q.ay);
    proj = wx * ux + wy * uy;
    span = ux * ux + uy * uy;
    r.cx = q.ax;
    r.cy = q.ay;
    if (span == 0) begin
      r.region = cps_pkg::REGION_ZERO;
    end else if (proj <= 0) begin
      r.region = cps_pkg::REGION_A;
    end else if (proj >= span) begin
      r.cx = q.bx;
      r.cy = q.by;
      r.region = cps_pkg::REGION_B;
    end else begin
      ratio = (proj <<< cps_pkg::RatioBits) / span;
      mag = (ux < 0) ? -ux : ux;
      ofs = (mag * ratio + (128'sd1 <<< (cps_pkg::RatioBits - 1))) >>> cps_pkg::RatioBits;
      r.cx = q.ax + ((ux < 0) ? -ofs[31:0] : ofs[31:0]);
      mag = (uy < 0) ? -uy : uy;
      ofs = (mag * ratio + (128'sd1 <<< (cps_pkg::RatioBits - 1))) >>> cps_pkg::RatioBits;
      r.cy = q.ay + ((uy < 0) ? -ofs[31:0] : ofs[31:0]);
      r.region = cps_pkg::REGION_INNER;
    end
    return r;
  endfunction

  // Accepted requests queue their expectation; each strobe is checked against the oldest.
  always @(posedge clk_i) begin
    nearest_t want;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_points.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result strobe at cycle %0d", cycles);
      end else begin
        want = pending_points.pop_front();
        region_hits[region_o]++;
        if (closest_x_o !== want.cx || closest_y_o !== want.cy || region_o !== want.region)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected (%h,%h) region %0d, got (%h,%h) region %0d",
                     want.cx, want.cy, want.region, closest_x_o, closest_y_o, region_o);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      requests++;
      if (typed_rows.size() != 0 && typed_rows[0].q == {point_x_i, point_y_i, a_x_i,
          a_y_i, b_x_i, b_y_i} && typed_rows[0].typed) begin
        pending_points.insert(pending_points.size(), typed_rows[0].want);
        void'(typed_rows.pop_front());
      end else begin
        pending_points.insert(pending_points.size(),
                              nearest_point({point_x_i, point_y_i, a_x_i, a_y_i,
                                             b_x_i, b_y_i}));
      end
    end
  end

  // Drive one request after an optional idle gap; start is never lowered and raised in one step.
  task automatic send_query(input query_t q, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    {point_x_i, point_y_i, a_x_i, a_y_i, b_x_i, b_y_i} <= q;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 5))
      0: return CoordMax;
      1: return CoordMin;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Random query shapes: near-segment points, noise, zero length, edge values, small coordinates.
  function automatic query_t random_query();
    query_t q;
    int     roll, ux, uy, k;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (roll < 60) begin
      q.ax = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      q.ay = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      ux = $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      uy = $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      q.bx = q.ax + ux;
      q.by = q.ay + uy;
      k = $urandom_range(0, 12);
      q.px = q.ax + (ux / 8) * (k - 2) + $signed($urandom_range(0, 2000)) - 1000;
      q.py = q.ay + (uy / 8) * (k - 2) + $signed($urandom_range(0, 2000)) - 1000;
    end else if (roll < 70) begin
      q = {$urandom, $urandom, $urandom, $urandom, 64'd0};
      q.bx = q.ax;
      q.by = q.ay;
    end else if (roll < 80) begin
      q = {edge_value(), edge_value(), edge_value(), edge_value(), edge_value(),
           edge_value()};
    end else begin
      q.px = $signed($urandom_range(0, 2000)) - 1000;
      q.py = $signed($urandom_range(0, 2000)) - 1000;
      q.ax = $signed($urandom_range(0, 2000)) - 1000;
      q.ay = $signed($urandom_range(0, 2000)) - 1000;
      q.bx = $signed($urandom_range(0, 2000)) - 1000;
      q.by = $signed($urandom_range(0, 2000)) - 1000;
    end
    return q;
  endfunction

  initial begin
    vector_t directed[$];
    directed = '{
      // Zero-length segments return A.
      '{'{32'd5, 32'd7, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        '{32'd0, 32'd0, cps_pkg::REGION_ZERO}},
      '{'{CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax}, 1'b1,
        '{CoordMax, CoordMax, cps_pkg::REGION_ZERO}},
      // Point on A, behind A and beside A.
      '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b1,
        '{32'd0, 32'd0, cps_pkg::REGION_A}},
      '{'{-32'sd50, 32'd3, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b1,
        '{32'd0, 32'd0, cps_pkg::REGION_A}},
      '{'{32'd0, 32'd100, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b1,
        '{32'd0, 32'd0, cps_pkg::REGION_A}},
      // Point on B, and beyond B.
      '{'{32'd10, 32'd0, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b1,
        '{32'd10, 32'd0, cps_pkg::REGION_B}},
      '{'{32'd90, -32'sd4, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b1,
        '{32'd10, 32'd0, cps_pkg::REGION_B}},
      // Full-range extremes.
      '{'{CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMax}, 1'b1,
        '{CoordMax, CoordMax, cps_pkg::REGION_B}},
      '{'{CoordMin, CoordMin, CoordMax, CoordMax, CoordMin, CoordMin}, 1'b1,
        '{CoordMin, CoordMin, cps_pkg::REGION_B}},
      '{'{CoordMax, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax}, 1'b0, '0},
      '{'{CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax}, 1'b0, '0},
      // Interior: exact midpoint of an axis-aligned segment, then untyped cases checked against nearest_point.
      '{'{32'h0001_0000, 32'd5, 32'd0, 32'd0, 32'h0002_0000, 32'd0}, 1'b1,
        '{32'h0001_0000, 32'd0, cps_pkg::REGION_INNER}},
      '{'{32'd0, 32'd0, 32'd100, 32'd100, -32'sd100, -32'sd100}, 1'b0, '0},
      '{'{32'd1, 32'd7, 32'd0, 32'd0, 32'd3, 32'd0}, 1'b0, '0},
      '{'{32'd2, -32'sd9, 32'd0, 32'd0, -32'sd3, 32'd7}, 1'b0, '0},
      '{'{32'h1234_5678, 32'h0ABC_DEF0, CoordMin, 32'd0, CoordMax, 32'd1}, 1'b0, '0},
      '{'{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF}, 1'b0, '0}
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table first.
    foreach (directed[i]) begin
      if (directed[i].typed) typed_rows.insert(typed_rows.size(), directed[i]);
      send_query(directed[i].q, pick_gap(1'b0));
    end

    // Random requests, with bursts free of gaps and one full drain midway.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk_i);
      end
      send_query(random_query(), pick_gap((n % 200) < 40));
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent; results by region: A %0d, B %0d, interior %0d, zero %0d",
             requests, region_hits[cps_pkg::REGION_A], region_hits[cps_pkg::REGION_B],
             region_hits[cps_pkg::REGION_INNER], region_hits[cps_pkg::REGION_ZERO]);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cps_pkg.sv
hw/rtl/closest_point_on_segment_unit.sv
test/closest_point_on_segment_unit_tb.sv
